>>> rtl/tcc_pkg.sv
// Shared types and constants for the text console cursor block.
// Depends on nothing; every other file in rtl/ imports it.
package tcc_pkg;

    // Control bytes recognised by the classifier
    localparam logic [7:0] CH_TAB      = 8'd9;
    localparam logic [7:0] CH_NL       = 8'd10;
    localparam logic [7:0] CH_CR       = 8'd13;
    localparam logic [6:0] GLYPH_SPACE = 7'd32;
    localparam logic [7:0] GLYPH_LIMIT = 8'd128;

    // Tab stop spacing uses only the low four bits of (tab_width - 1)
    localparam logic [4:0] TAB_MASK = 5'h0F;

    // Configuration register indexes and reset values
    localparam logic [1:0] REG_TAB_WIDTH = 2'd0;
    localparam logic [1:0] REG_NUM_COLS  = 2'd1;
    localparam logic [1:0] REG_NUM_ROWS  = 2'd2;

    localparam logic [4:0] TAB_WIDTH_RST = 5'd4;
    localparam logic [7:0] NUM_COLS_RST  = 8'd79;
    localparam logic [5:0] NUM_ROWS_RST  = 6'd28;

    // Depth of the queue between front and back
    localparam int QDEPTH = 2;

    typedef enum logic [1:0] {
        K_PRINT,
        K_TAB,
        K_NL,
        K_CR
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [6:0] glyph;
    } item_t;

    typedef struct packed {
        logic [4:0] tab_width;
        logic [7:0] num_cols;
        logic [5:0] num_rows;
    } cfg_t;

    typedef struct packed {
        logic       draw;
        logic [5:0] draw_row;
        logic [7:0] draw_col;
        logic [6:0] glyph_code;
        logic [6:0] scroll_lines;
    } result_t;

    typedef enum logic {
        BK_IDLE,
        BK_TAB
    } back_state_t;

endpackage

>>> rtl/tcc_front.sv
// Front end: classifies each incoming byte into an item for the queue.
// Depends on tcc_pkg.
module tcc_front (
    input  logic [7:0]     char_code,
    output tcc_pkg::item_t item
);
    import tcc_pkg::*;

    // Sort the byte into control kinds and map high bytes to a space glyph
    always_comb
    begin
        case (char_code)
            CH_NL:   item.kind = K_NL;
            CH_CR:   item.kind = K_CR;
            CH_TAB:  item.kind = K_TAB;
            default: item.kind = K_PRINT;
        endcase
        item.glyph = (char_code < GLYPH_LIMIT) ? char_code[6:0] : GLYPH_SPACE;
    end

endmodule

>>> rtl/tcc_queue.sv
// Short register queue that decouples the classifier from the cursor engine.
// Depends on tcc_pkg.
module tcc_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  tcc_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output tcc_pkg::item_t head_item
);
    import tcc_pkg::*;

    localparam int PTR_W = $clog2(QDEPTH);
    localparam int CNT_W = $clog2(QDEPTH + 1);

    item_t            entry_reg [QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_W'(QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = entry_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> rtl/tcc_tab_unit.sv
// Iterative tab stop rounding: one remainder bit per cycle, MSB first.
// Depends on tcc_pkg (imported for house consistency only; nothing from it is used).
module tcc_tab_unit #(
    parameter int MAX_COLS = 256
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [$clog2(2*MAX_COLS):0]     value,
    input  logic [4:0]                      tab_w,
    output logic                            done,
    output logic [$clog2(2*MAX_COLS)-1:0]   col
);
    import tcc_pkg::*;

    localparam int COL_W = $clog2(2 * MAX_COLS);
    localparam int VW    = COL_W + 1;
    localparam int CNT_W = $clog2(VW + 1);
    localparam logic [COL_W-1:0] COL_MASK = COL_W'(2 * MAX_COLS - 1);

    logic [VW-1:0]    value_reg;
    logic [VW-1:0]    shift_reg, shift_next;
    logic [4:0]       tw_reg;
    logic [4:0]       rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [5:0]       rem_trial;
    logic [4:0]       pad;
    logic [VW+3:0]    sum;

    assign done = (cnt_reg == '0);

    // One restoring remainder step per cycle
    always_comb
    begin
        rem_trial  = {rem_reg, shift_reg[VW-1]};
        rem_next   = rem_reg;
        shift_next = shift_reg;
        cnt_next   = cnt_reg;
        if (start)
        begin
            rem_next   = '0;
            shift_next = value;
            cnt_next   = CNT_W'(VW);
        end
        else if (cnt_reg != '0)
        begin
            if (rem_trial >= {1'b0, tw_reg})
            begin
                rem_next = 5'(rem_trial - {1'b0, tw_reg});
            end
            else
            begin
                rem_next = rem_trial[4:0];
            end
            shift_next = {shift_reg[VW-2:0], 1'b0};
            cnt_next   = cnt_reg - CNT_W'(1);
        end
    end

    // Round up to the next multiple: add (tw - rem) unless already aligned
    always_comb
    begin
        pad = (rem_reg == '0) ? 5'd0 : tw_reg - rem_reg;
        sum = {4'b0, value_reg} + {{(VW - 1){1'b0}}, pad};
        col = sum[COL_W-1:0] & COL_MASK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        shift_reg <= shift_next;
        if (start)
        begin
            value_reg <= value;
            tw_reg    <= tab_w;
        end
    end

endmodule

>>> rtl/tcc_back.sv
// Back end: cursor state, wrap and scroll logic, and the result register.
// Depends on tcc_pkg and tcc_tab_unit.
module tcc_back #(
    parameter int MAX_COLS = 256,
    parameter int MAX_ROWS = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  tcc_pkg::cfg_t     cfg,
    input  logic              q_valid,
    input  tcc_pkg::item_t    q_item,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_stall,
    output tcc_pkg::result_t  result
);
    import tcc_pkg::*;

    localparam int COL_W = $clog2(2 * MAX_COLS);
    localparam int VW    = COL_W + 1;
    localparam int ROW_W = $clog2(MAX_ROWS + 2) + 1;
    localparam int RU_W  = ROW_W + 7;
    localparam logic [COL_W-1:0] COL_MASK = COL_W'(2 * MAX_COLS - 1);
    localparam logic signed [ROW_W-1:0] ROW_LIMIT = ROW_W'(MAX_ROWS + 1);

    back_state_t state_reg, state_next;

    logic [COL_W-1:0]        col_reg, col_next;
    logic signed [ROW_W-1:0] row_reg, row_next;
    logic                    pend_reg, pend_next;
    logic                    out_valid_reg, out_valid_next;
    result_t                 res_reg, res_next;

    logic             out_free;
    logic             tab_start;
    logic             fire;
    logic             tab_done;
    logic [COL_W-1:0] tab_col;
    logic [VW-1:0]    tab_value;
    logic [4:0]       tw_m1;
    logic [4:0]       tw;

    logic signed [ROW_W-1:0] row_set, row_wrap, row_fin;
    logic [COL_W-1:0]        col_sel, col_wrap, col_inc;
    logic                    wrap, over;
    logic [5:0]              rows_eff;
    logic [RU_W-1:0]         row_u, rows_eff_u, scroll_u, rows_m1_u, row_out_u;
    logic [COL_W+7:0]        col_ext;

    function automatic logic signed [ROW_W-1:0] adv(input logic signed [ROW_W-1:0] r);
        adv = (r < ROW_LIMIT) ? r + ROW_W'(1) : r;
    endfunction

    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign result    = res_reg;

    // Effective tab width and the value that is rounded up
    assign tw_m1     = (cfg.tab_width - 5'd1) & TAB_MASK;
    assign tw        = tw_m1 + 5'd1;
    assign tab_value = {1'b0, col_reg} + VW'(1);

    tcc_tab_unit #(
        .MAX_COLS (MAX_COLS)
    ) u_tab (
        .clk   (clk),
        .rst_n (rst_n),
        .start (tab_start),
        .value (tab_value),
        .tab_w (tw),
        .done  (tab_done),
        .col   (tab_col)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid && q_item.kind == K_TAB)
                begin
                    state_next = BK_TAB;
                end
            end
            BK_TAB:
            begin
                if (tab_done && out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        tab_start = 1'b0;
        fire      = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_item.kind == K_TAB)
                    begin
                        tab_start = 1'b1;
                    end
                    else if (out_free)
                    begin
                        fire = 1'b1;
                    end
                end
            end
            BK_TAB:
            begin
                fire = tab_done && out_free;
            end
            default:
            begin
                fire = 1'b0;
            end
        endcase
        q_pop = fire;
    end

    // Cursor update for the item at the head of the queue
    always_comb
    begin
        row_set  = (pend_reg && q_item.kind != K_CR) ? adv(row_reg) : row_reg;
        col_sel  = (q_item.kind == K_TAB) ? tab_col : col_reg;
        wrap     = ({8'b0, col_sel} >= {{COL_W{1'b0}}, cfg.num_cols});
        row_wrap = wrap ? adv(row_set) : row_set;
        col_wrap = wrap ? '0 : col_sel;
        col_inc  = (col_wrap + COL_W'(1)) & COL_MASK;

        // Scroll by the rows past the last one and pin the row there
        rows_eff   = (cfg.num_rows == '0) ? 6'd1 : cfg.num_rows;
        row_u      = {7'b0, row_wrap};
        rows_eff_u = {{(ROW_W + 1){1'b0}}, rows_eff};
        rows_m1_u  = rows_eff_u - RU_W'(1);
        over       = (row_u >= rows_eff_u);
        scroll_u   = over ? row_u - rows_m1_u : '0;
        row_fin    = over ? $signed(rows_m1_u[ROW_W-1:0]) : row_wrap;
        row_out_u  = {7'b0, row_fin};
        col_ext    = {8'b0, col_wrap};

        res_next  = '0;
        row_next  = row_reg;
        col_next  = col_reg;
        pend_next = pend_reg;
        case (q_item.kind)
            K_NL:
            begin
                row_next  = row_set;
                col_next  = '0;
                pend_next = 1'b1;
            end
            K_CR:
            begin
                col_next = '0;
            end
            default:
            begin
                pend_next = 1'b0;
                if (row_wrap[ROW_W-1])
                begin
                    row_next = row_wrap;
                    col_next = col_wrap;
                end
                else
                begin
                    row_next              = row_fin;
                    col_next              = col_inc;
                    res_next.draw         = 1'b1;
                    res_next.draw_row     = row_out_u[5:0];
                    res_next.draw_col     = col_ext[7:0];
                    res_next.glyph_code   = q_item.glyph;
                    res_next.scroll_lines = scroll_u[6:0];
                end
            end
        endcase
    end

    // Result register hand-off
    always_comb
    begin
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            col_reg       <= '0;
            row_reg       <= '1;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                col_reg  <= col_next;
                row_reg  <= row_next;
                pend_reg <= pend_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

endmodule

>>> rtl/text_console_cursor.sv
// Top level of the text console cursor: configuration registers and the
// front, queue and back parts. Depends on tcc_pkg, tcc_front, tcc_queue, tcc_back.
//
// Usage:
//   Input channel (in_valid / in_stall / char_code) takes one byte per transfer.
//   Output channel (out_valid / out_stall / draw ... scroll_lines) gives exactly
//   one result per byte, in order; draw is 0 for newline, carriage return and
//   bytes that fall before the first row, with all other fields 0.
//   Configuration channel (cfg_valid / cfg_ready / cfg_index / cfg_data) writes
//   tab_width (0), num_cols (1) and num_rows (2); cfg_ready is always high.
//   A plain byte passes through a queue entry and then the result register.
//   A tab runs the tab stop rounding unit, one remainder bit per cycle over
//   the col+1 value, and the queue waits until it is done. Plain bytes sustain
//   one per cycle while the receiver does not stall and no tab is running.
//   A two-entry queue sits between classifier and cursor engine, so bytes
//   keep being taken while a result waits in the output register; when the
//   receiver stalls, the result holds and in_stall rises once the queue fills.
//   Reset: column 0, row -1, no newline pending, registers 4 / 79 / 28,
//   queue and output empty. No clearing pass is needed.
module text_console_cursor #(
    parameter int MAX_COLS = 256,
    parameter int MAX_ROWS = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] char_code,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       draw,
    output logic [5:0] draw_row,
    output logic [7:0] draw_col,
    output logic [6:0] glyph_code,
    output logic [6:0] scroll_lines,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);
    import tcc_pkg::*;

    cfg_t    cfg_reg;
    item_t   front_item;
    item_t   head_item;
    logic    q_full, q_push, q_pop, q_head_valid;
    result_t result;

    // Configuration register file
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tab_width <= TAB_WIDTH_RST;
            cfg_reg.num_cols  <= NUM_COLS_RST;
            cfg_reg.num_rows  <= NUM_ROWS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_TAB_WIDTH: cfg_reg.tab_width <= cfg_data[4:0];
                REG_NUM_COLS:  cfg_reg.num_cols  <= cfg_data;
                REG_NUM_ROWS:  cfg_reg.num_rows  <= cfg_data[5:0];
                default:       cfg_reg           <= cfg_reg;
            endcase
        end
    end

    // Front: classify and queue
    assign in_stall = q_full;
    assign q_push   = in_valid && !in_stall;

    tcc_front u_front (
        .char_code (char_code),
        .item      (front_item)
    );

    tcc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (front_item),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_item  (head_item)
    );

    // Back: cursor engine and result register
    tcc_back #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_head_valid),
        .q_item    (head_item),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .result    (result)
    );

    assign draw         = result.draw;
    assign draw_row     = result.draw_row;
    assign draw_col     = result.draw_col;
    assign glyph_code   = result.glyph_code;
    assign scroll_lines = result.scroll_lines;

endmodule

>>> tb/tcc_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the text console cursor: tracks register writes, predicts each
// result from the accepted bytes and compares the result channel. Uses tcc_pkg.
module tcc_checker #(
    parameter int MAX_COLS = 256,
    parameter int MAX_ROWS = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [7:0] char_code,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic       draw,
    input  logic [5:0] draw_row,
    input  logic [7:0] draw_col,
    input  logic [6:0] glyph_code,
    input  logic [6:0] scroll_lines,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    output int         fail_count,
    output int         results_owed
);
    import tcc_pkg::*;

    // Shadow registers and cursor state
    logic [4:0]  tab_w;
    logic [7:0]  cols;
    logic [5:0]  rows;
    int unsigned col;
    int          row;
    bit          nl_pending;

    result_t     cells_due[$];
    result_t     want;
    result_t     got;

    // Row moves down one line, capped so a huge scroll stays bounded
    function automatic void advance_line();
        if (row < MAX_ROWS + 1)
        begin
            row = row + 1;
        end
    endfunction

    // Expected result for one byte; updates the cursor state
    function automatic result_t predict_cell(input logic [7:0] ch);
        result_t     r;
        int unsigned tw;
        int unsigned nxt;
        int          rows_eff;
        int unsigned scroll;

        r = '0;
        if (ch == CH_NL)
        begin
            if (nl_pending)
            begin
                advance_line();
            end
            col = 0;
            nl_pending = 1'b1;
            return r;
        end
        if (ch == CH_CR)
        begin
            col = 0;
            return r;
        end
        // any other byte settles a deferred newline first
        if (nl_pending)
        begin
            advance_line();
            nl_pending = 1'b0;
        end
        if (ch == CH_TAB)
        begin
            tw  = ((32'(tab_w) - 32'd1) & 32'(TAB_MASK)) + 32'd1;
            nxt = col + 1;
            col = (((nxt + tw - 1) / tw) * tw) & (2 * MAX_COLS - 1);
        end
        if (col >= cols)
        begin
            advance_line();
            col = 0;
        end
        // nothing is placed before the first row exists
        if (row < 0)
        begin
            return r;
        end
        rows_eff = (rows == 0) ? 1 : int'(rows);
        scroll   = 0;
        if (row >= rows_eff)
        begin
            scroll = row - rows_eff + 1;
            row    = rows_eff - 1;
        end
        r.draw         = 1'b1;
        r.draw_row     = 6'(row);
        r.draw_col     = 8'(col);
        r.glyph_code   = (ch < GLYPH_LIMIT) ? ch[6:0] : GLYPH_SPACE;
        r.scroll_lines = 7'(scroll);
        col = (col + 1) & (2 * MAX_COLS - 1);
        return r;
    endfunction

    task automatic check_field(input string field, input int unsigned want_v,
                               input int unsigned got_v);
        if (want_v != got_v)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, field, want_v, got_v);
            fail_count = fail_count + 1;
        end
    endtask

    // Watch all three channels at each rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tab_w      = TAB_WIDTH_RST;
            cols       = NUM_COLS_RST;
            rows       = NUM_ROWS_RST;
            col        = 0;
            row        = -1;
            nl_pending = 1'b0;
            cells_due.delete();
            results_owed <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_TAB_WIDTH: tab_w = cfg_data[4:0];
                    REG_NUM_COLS:  cols  = cfg_data;
                    REG_NUM_ROWS:  rows  = cfg_data[5:0];
                    default: ;
                endcase
            end
            // result transfer against the oldest prediction
            if (out_valid && !out_stall)
            begin
                got = {draw, draw_row, draw_col, glyph_code, scroll_lines};
                if (cells_due.size() == 0)
                begin
                    $display("%0t ns: unexpected result, expected none, actual %h",
                             $time, got);
                    fail_count = fail_count + 1;
                end
                else
                begin
                    want = cells_due.pop_front();
                    check_field("draw", want.draw, got.draw);
                    check_field("draw_row", want.draw_row, got.draw_row);
                    check_field("draw_col", want.draw_col, got.draw_col);
                    check_field("glyph_code", want.glyph_code, got.glyph_code);
                    check_field("scroll_lines", want.scroll_lines, got.scroll_lines);
                end
            end
            if (in_valid && !in_stall)
            begin
                cells_due.push_back(predict_cell(char_code));
            end
            results_owed <= cells_due.size();
        end
    end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// Stimulus top for the text console cursor: drives bytes, register writes and
// receiver stalls. Depends on tcc_pkg, text_console_cursor and tcc_checker.
module tb;
    import tcc_pkg::*;

    localparam int MAX_COLS    = 256;
    localparam int MAX_ROWS    = 64;
    localparam int SETTLE      = 20;
    localparam int HOLD_CYCLES = 60;
    localparam int PHASE_ITEMS = 200;
    localparam int CYCLE_LIMIT = 400000;

    logic       clk;
    logic       rst_n        = 1'b0;
    logic       in_valid     = 1'b0;
    logic       in_stall;
    logic [7:0] char_code    = 8'd0;
    logic       out_valid;
    logic       out_stall    = 1'b0;
    logic       draw;
    logic [5:0] draw_row;
    logic [7:0] draw_col;
    logic [6:0] glyph_code;
    logic [6:0] scroll_lines;
    logic       cfg_valid    = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index    = REG_TAB_WIDTH;
    logic [7:0] cfg_data     = 8'd0;
    int         fail_count;
    int         results_owed;

    bit         quiet    = 1'b0;
    bit         hold_req = 1'b0;
    int         cycle_count = 0;

    // Opening bytes at reset settings: before the first row, controls, extremes
    logic [7:0] opening [18] = '{8'd65, CH_TAB, CH_CR, CH_NL, CH_NL, 8'd90, 8'd0,
                                 8'd255, 8'd127, 8'd128, CH_TAB, CH_TAB, CH_CR,
                                 8'd200, CH_NL, 8'd33, CH_TAB, 8'd126};

    // Fixed register settings for phases 0 to 5: tab_width, num_cols, num_rows
    int unsigned tab_set  [6] = '{1, 16, 0, 31, 17, 5};
    int unsigned cols_set [6] = '{1, 255, 0, 8, 3, 40};
    int unsigned rows_set [6] = '{1, 63, 0, 4, 2, 12};

    text_console_cursor #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) uut (.*);

    tcc_checker #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Receiver: random stalls, or a long hold-off when asked
    always
    begin
        @(negedge clk);
        if (hold_req)
        begin
            out_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clk);
            hold_req = 1'b0;
        end
        out_stall <= !quiet && ($urandom_range(99) < 20);
    end

    function automatic logic [7:0] any_printable();
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while (b == CH_NL || b == CH_CR || b == CH_TAB);
        return b;
    endfunction

    // One byte transfer, with an optional random gap before it
    task automatic put_char(input logic [7:0] ch, input bit may_pause);
        if (may_pause && !quiet && $urandom_range(99) < 20)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        in_valid  <= 1'b1;
        char_code <= ch;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        while (results_owed != 0)
            @(negedge clk);
    endtask

    // Register write once the block has gone quiet
    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        in_valid <= 1'b0;
        wait_drained();
        repeat (SETTLE) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Random text: mostly lines of printable bytes, with controls mixed in
    task automatic run_traffic(input int count);
        int done_here;
        int pick;
        int len;

        done_here = 0;
        while (done_here < count)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
            begin
                put_char(any_printable(), 1'b1);
                done_here = done_here + 1;
            end
            else if (pick < 57)
            begin
                put_char(CH_NL, 1'b1);
                done_here = done_here + 1;
            end
            else if (pick < 62)
            begin
                put_char(CH_CR, 1'b1);
                done_here = done_here + 1;
            end
            else if (pick < 75)
            begin
                put_char(CH_TAB, 1'b1);
                done_here = done_here + 1;
            end
            else if (pick < 86)
            begin
                len = $urandom_range(1, 40);
                repeat (len) put_char(any_printable(), 1'b1);
                put_char(CH_NL, 1'b1);
                done_here = done_here + len + 1;
            end
            else if (pick < 89)
            begin
                // enough newlines to hit the row cap
                len = $urandom_range(2, 70);
                repeat (len) put_char(CH_NL, 1'b1);
                done_here = done_here + len;
            end
            else if (pick < 90)
            begin
                // wide line to reach the far columns
                len = $urandom_range(60, 280);
                repeat (len)
                    put_char(($urandom_range(9) == 0) ? CH_TAB : any_printable(), 1'b1);
                done_here = done_here + len;
            end
            else
            begin
                put_char(8'($urandom_range(255)), 1'b1);
                done_here = done_here + 1;
            end
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (opening[i])
            put_char(opening[i], 1'b1);

        for (int p = 0; p < 8; p++)
        begin
            if (p < 6)
            begin
                write_reg(REG_TAB_WIDTH, 8'(tab_set[p]));
                write_reg(REG_NUM_COLS, 8'(cols_set[p]));
                write_reg(REG_NUM_ROWS, 8'(rows_set[p]));
            end
            else
            begin
                write_reg(REG_NUM_ROWS, 8'($urandom_range(63)));
                write_reg(REG_NUM_COLS, 8'($urandom_range(255)));
                write_reg(REG_TAB_WIDTH, 8'($urandom_range(31)));
            end
            case (p)
                3:
                begin
                    // back-to-back transfers, no random gaps and no receiver stalls
                    quiet = 1'b1;
                    run_traffic(PHASE_ITEMS);
                    quiet = 1'b0;
                end
                4:
                begin
                    // receiver holds off while bytes keep coming
                    hold_req = 1'b1;
                    repeat (12) put_char(any_printable(), 1'b0);
                    run_traffic(PHASE_ITEMS - 12);
                end
                5:
                begin
                    run_traffic(PHASE_ITEMS / 2);
                    in_valid <= 1'b0;
                    wait_drained();
                    run_traffic(PHASE_ITEMS / 2);
                end
                default:
                    run_traffic(PHASE_ITEMS);
            endcase
        end

        in_valid <= 1'b0;
        wait_drained();
        repeat (SETTLE) @(negedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
